// ----- src/wbps_pkg.sv -----
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

   // Longest signature the window can hold
   localparam int PATTERN_MAX_DEF = 16;

   // Width of the pattern_length register
   localparam int LEN_W = 5;

   // Configuration port: 64-bit data, registers at 8-byte strides
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;

   // Register index, taken from paddr[5:3]
   typedef enum logic [2:0] {
      REG_PATTERN_LOW  = 3'd0,
      REG_PATTERN_HIGH = 3'd1,
      REG_WILDCARD     = 3'd2,
      REG_LENGTH       = 3'd3,
      REG_REGION_BASE  = 3'd4
   } reg_index_type;

   // One input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       region_end;
   } req_type;

   // One result item
   typedef struct packed {
      logic        found;
      logic [31:0] match_address;
   } rsp_type;

   // Configuration register contents
   typedef struct packed {
      logic [63:0]      pattern_low_bytes;
      logic [63:0]      pattern_high_bytes;
      logic [15:0]      wildcard_mask;
      logic [LEN_W-1:0] pattern_length;
      logic [31:0]      region_base;
   } cfg_type;

endpackage

// ----- src/wbps_csr.sv -----
// Configuration register file of the pattern scanner, APB-style access.
module wbps_csr import wbps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          wr_en;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1:3]);
   assign wr_en     = psel && penable && pwrite && pready;

   // Decode the write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_PATTERN_LOW:  cfg_in.pattern_low_bytes  = pwdata;
            REG_PATTERN_HIGH: cfg_in.pattern_high_bytes = pwdata;
            REG_WILDCARD:     cfg_in.wildcard_mask      = pwdata[15:0];
            REG_LENGTH:       cfg_in.pattern_length     = pwdata[LEN_W-1:0];
            REG_REGION_BASE:  cfg_in.region_base        = pwdata[31:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_low_bytes  <= '0;
         cfg_ff.pattern_high_bytes <= '0;
         cfg_ff.wildcard_mask      <= '0;
         cfg_ff.pattern_length     <= LEN_W'(1);
         cfg_ff.region_base        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_index)
         REG_PATTERN_LOW:  prdata = cfg_ff.pattern_low_bytes;
         REG_PATTERN_HIGH: prdata = cfg_ff.pattern_high_bytes;
         REG_WILDCARD:     prdata = CSR_DATA_W'(cfg_ff.wildcard_mask);
         REG_LENGTH:       prdata = CSR_DATA_W'(cfg_ff.pattern_length);
         REG_REGION_BASE:  prdata = CSR_DATA_W'(cfg_ff.region_base);
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/wbps_match.sv -----
// Sliding byte window, scan state and combinational signature compare.
module wbps_match import wbps_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type item,
   input  cfg_type cfg,
   output logic    emit,
   output rsp_type rsp
);

   localparam int IDX_W  = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int FILL_W = $clog2(PATTERN_MAX + 1);
   localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(PATTERN_MAX);
   localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(PATTERN_MAX);

   logic [7:0]        window_ff [PATTERN_MAX];
   logic [7:0]        window_in [PATTERN_MAX];
   logic [31:0]       offset_ff;
   logic [31:0]       offset_in;
   logic              done_ff;
   logic              done_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;

   logic [7:0]        shifted [PATTERN_MAX];
   logic [FILL_W-1:0] fill_next;
   logic [LEN_W-1:0]  len_eff;
   logic [LEN_W-1:0]  pos [PATTERN_MAX];
   logic [127:0]      signature;
   logic              hit;

   assign signature = {cfg.pattern_high_bytes, cfg.pattern_low_bytes};

   // Shift the new byte into the window
   always_comb begin
      shifted[0] = item.data_byte;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         shifted[k] = window_ff[k-1];
      end
   end

   // Clamp the length, count valid bytes, compare every signature position
   always_comb begin
      if (cfg.pattern_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (cfg.pattern_length > MAX_LEN) begin
         len_eff = MAX_LEN;
      end else begin
         len_eff = cfg.pattern_length;
      end
      fill_next = (fill_ff == MAX_FILL) ? fill_ff : fill_ff + FILL_W'(1);
      hit = LEN_W'(fill_next) >= len_eff;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         pos[i] = len_eff - LEN_W'(i) - LEN_W'(1);
         if (LEN_W'(i) < len_eff && !cfg.wildcard_mask[i] &&
             shifted[pos[i][IDX_W-1:0]] != signature[i*8 +: 8]) begin
            hit = 1'b0;
         end
      end
   end

   // Result and next scan state
   always_comb begin
      emit              = 1'b0;
      rsp.found         = 1'b0;
      rsp.match_address = '0;
      window_in         = window_ff;
      offset_in         = offset_ff;
      done_in           = done_ff;
      fill_in           = fill_ff;
      if (!done_ff) begin
         emit              = hit || item.region_end;
         rsp.found         = hit;
         rsp.match_address = hit ?
            cfg.region_base + offset_ff - 32'(len_eff) + 32'd1 : 32'd0;
      end
      if (step) begin
         if (item.region_end && (done_ff || hit || item.region_end)) begin
            // end of region clears the scan
            offset_in = '0;
            done_in   = 1'b0;
            fill_in   = '0;
         end else if (!done_ff) begin
            window_in = shifted;
            fill_in   = fill_next;
            if (hit) begin
               done_in = 1'b1;
            end else begin
               offset_in = offset_ff + 32'd1;
            end
         end
      end
   end

   // Hold the window bytes; entries past the fill count are never compared
   always_ff @(posedge clock) begin
      window_ff <= window_in;
   end

   // Hold the scan control state
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         done_ff   <= 1'b0;
         fill_ff   <= '0;
      end else begin
         offset_ff <= offset_in;
         done_ff   <= done_in;
         fill_ff   <= fill_in;
      end
   end

   // A region that already matched gives no further result
   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !emit)
      else $error("result after match in the same region");

   // A not-found result only comes with the last byte of a region
   assert property (@(posedge clock) disable iff (reset)
      (emit && !rsp.found) |-> (item.region_end && rsp.match_address == 32'd0))
      else $error("not-found result away from region end");

   // A match before the region end suppresses the rest of the region
   assert property (@(posedge clock) disable iff (reset)
      (step && emit && rsp.found && !item.region_end) |=> done_ff)
      else $error("scan not marked done after match");

   // The fill count never passes the window depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= MAX_FILL)
      else $error("window fill count overflow");

endmodule

// ----- src/wildcard_byte_pattern_scanner_top.sv -----
// Top level of the wildcard byte pattern scanner: item registers and handshakes.
//
// Scans a byte stream for a signature of 1 to PATTERN_MAX bytes with per-byte
// wildcards and returns one item per region: the address of the first match
// (found = 1, at most one per region) or found = 0 with the last byte of the
// region. The block takes one byte per clock cycle when the result side is
// not stalled; a byte enters the input register, is compared against the whole
// signature by the window compare while held there, and its result is loaded
// into the result register when the byte is processed. The user must write
// registers through the APB-style port only while no bytes are in flight; the
// block does not enforce this. A write takes effect from the next byte.
module wildcard_byte_pattern_scanner_top import wbps_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   req_type item_ff;
   logic    item_valid_ff;
   logic    item_valid_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   logic    emit;
   rsp_type rsp_next;
   logic    advance;

   wbps_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   wbps_match #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_match (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (item_ff),
      .cfg   (cfg),
      .emit  (emit),
      .rsp   (rsp_next)
   );

   // Process the held item unless its result has nowhere to go
   assign advance   = item_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   // Fill and drain the input register
   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_valid && req_ready) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   // Load or drain the result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture payloads
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (advance && emit) begin
         rsp_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A new result never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(advance && emit))
      else $error("pending result overwritten");

   // An accepted byte is held in the input register in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> item_valid_ff)
      else $error("accepted item lost");

   // The input side stalls only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (item_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without cause");

endmodule

// ----- verif/wbps_match_checker.sv -----
// Checker for the wildcard byte pattern scanner: predicts and compares every result item.
module wbps_match_checker import wbps_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic                  pready,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   input  logic                  run_done,
   output int                    fail_count,
   output int                    pending_count,
   output int                    byte_count,
   output int                    report_count,
   output int                    hit_count
);

   localparam int WIN = PATTERN_MAX_DEF;

   // Shadow of the registers and of the scan state
   cfg_type    sig_cfg;
   logic [7:0] window [WIN];
   logic [31:0] offset;
   logic       matched;
   int         fill;
   logic       leftovers_checked;

   // Results still owed by the block, oldest first
   rsp_type    expected_reports [$];

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("ERROR: %s", msg);
   endtask

   task automatic clear_scan();
      for (int k = 0; k < WIN; k++) window[k] = 8'h00;
      offset  = '0;
      matched = 1'b0;
      fill    = 0;
   endtask

   function automatic logic [7:0] signature_at(input int i);
      if (i < 8) return sig_cfg.pattern_low_bytes[i*8 +: 8];
      return sig_cfg.pattern_high_bytes[(i-8)*8 +: 8];
   endfunction

   // Shift one byte into the window and work out the result it causes, if any
   task automatic advance_scan(input req_type item);
      int      len;
      logic    hit;
      rsp_type report;
      if (matched) begin
         if (item.region_end) clear_scan();
         return;
      end
      for (int k = WIN - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = item.data_byte;
      if (fill < WIN) fill++;
      len = sig_cfg.pattern_length;
      if (len < 1) len = 1;
      if (len > WIN) len = WIN;
      // Oldest byte of the window lines up with signature byte 0
      hit = (fill >= len);
      for (int i = 0; i < len; i++) begin
         if (!sig_cfg.wildcard_mask[i] && window[len-1-i] != signature_at(i)) hit = 1'b0;
      end
      if (hit) begin
         report.found         = 1'b1;
         report.match_address = sig_cfg.region_base + offset - 32'(len - 1);
         expected_reports.push_back(report);
         if (item.region_end) clear_scan();
         else matched = 1'b1;
      end else if (item.region_end) begin
         report = '0;
         expected_reports.push_back(report);
         clear_scan();
      end else begin
         offset++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type wanted;
      if (reset) begin
         sig_cfg                = '0;
         sig_cfg.pattern_length = LEN_W'(1);
         clear_scan();
         expected_reports.delete();
         leftovers_checked = 1'b0;
      end else begin
         // Track register writes
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[CSR_ADDR_W-1:3]))
               REG_PATTERN_LOW:  sig_cfg.pattern_low_bytes  = pwdata;
               REG_PATTERN_HIGH: sig_cfg.pattern_high_bytes = pwdata;
               REG_WILDCARD:     sig_cfg.wildcard_mask      = pwdata[15:0];
               REG_LENGTH:       sig_cfg.pattern_length     = pwdata[LEN_W-1:0];
               REG_REGION_BASE:  sig_cfg.region_base        = pwdata[31:0];
               default: ;
            endcase
         end
         // Predict from each accepted item
         if (req_valid && req_ready) begin
            byte_count++;
            advance_scan(req_data);
         end
         // Compare each accepted result with the oldest expectation
         if (rsp_valid && rsp_ready) begin
            report_count++;
            if (expected_reports.size() == 0) begin
               note_failure($sformatf("unexpected result: found=%0b address=%h",
                                      rsp_data.found, rsp_data.match_address));
            end else begin
               wanted = expected_reports.pop_front();
               if (wanted.found) hit_count++;
               if (rsp_data.found !== wanted.found)
                  note_failure($sformatf("result %0d found: expected %0b, got %0b",
                                         report_count, wanted.found, rsp_data.found));
               if (rsp_data.match_address !== wanted.match_address)
                  note_failure($sformatf("result %0d match_address: expected %h, got %h",
                                         report_count, wanted.match_address,
                                         rsp_data.match_address));
            end
         end
         // Flag results that never came
         if (run_done && !leftovers_checked) begin
            leftovers_checked = 1'b1;
            if (expected_reports.size() != 0)
               note_failure($sformatf("%0d expected results never arrived",
                                      expected_reports.size()));
         end
      end
      pending_count = expected_reports.size();
   end

endmodule

// ----- verif/tb_wildcard_byte_pattern_scanner_top.sv -----
// Testbench top of the wildcard byte pattern scanner: stimulus, receiver and verdict.
module tb_wildcard_byte_pattern_scanner_top;
   import wbps_pkg::*;

   localparam int HALF_PERIOD  = 4;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 120;
   localparam int PHASES       = 10;
   localparam int RANDOM_BYTES = 550;
   localparam int RUN_LIMIT    = 1_000_000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   logic                  run_done;

   int fail_count;
   int pending_count;
   int byte_count;
   int report_count;
   int hit_count;

   // Stimulus knobs and the signature currently loaded
   bit          idle_on;
   logic        stall_on;
   logic        hold_go;
   logic [63:0] cur_low;
   logic [63:0] cur_high;
   logic [15:0] cur_mask;
   logic [4:0]  cur_len;
   int          settings_count;
   int          mid_writes;

   wildcard_byte_pattern_scanner_top dut (.*);

   wbps_match_checker checker_i (.*);

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   function automatic int active_length();
      if (cur_len == 0) return 1;
      if (cur_len > PATTERN_MAX_DEF) return PATTERN_MAX_DEF;
      return cur_len;
   endfunction

   // Offer one item, with an occasional idle burst first, and hold until accepted
   task automatic send_byte(input logic [7:0] value, input logic last);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: value, region_end: last};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every result is in and the pipeline is empty
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_signature(input logic [63:0] low, input logic [63:0] high,
                                 input logic [15:0] mask, input logic [4:0] len,
                                 input logic [31:0] base);
      csr_write(REG_PATTERN_LOW, low);
      csr_write(REG_PATTERN_HIGH, high);
      csr_write(REG_WILDCARD, {48'h0, mask});
      csr_write(REG_LENGTH, {59'h0, len});
      csr_write(REG_REGION_BASE, {32'h0, base});
      cur_low  = low;
      cur_high = high;
      cur_mask = mask;
      cur_len  = len;
      settings_count++;
   endtask

   // Send one region; optionally plant the signature and change the length midway
   task automatic send_region(input int count, input bit plant, input bit narrow,
                              input bit split);
      logic [7:0]   region_bytes [$];
      logic [127:0] sig;
      int           len;
      int           at;
      int           pick;
      sig = {cur_high, cur_low};
      len = active_length();
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, len - 1);
         if (narrow && $urandom_range(0, 3) != 0) region_bytes.push_back(sig[pick*8 +: 8]);
         else region_bytes.push_back(8'($urandom));
      end
      if (plant && count >= len) begin
         at = $urandom_range(0, count - len);
         for (int i = 0; i < len; i++) begin
            if (!cur_mask[i]) region_bytes[at+i] = sig[i*8 +: 8];
         end
      end
      for (int k = 0; k < count; k++) begin
         if (split && count >= 2 && k == count / 2) begin
            wait_idle();
            cur_len = 5'($urandom_range(0, 31));
            csr_write(REG_LENGTH, {59'h0, cur_len});
            mid_writes++;
         end
         send_byte(region_bytes[k], k == count - 1);
      end
   endtask

   // Receiver: random stall bursts, plus one long hold-off
   initial begin
      bit hold_taken;
      int gap;
      hold_taken = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (stall_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            rsp_ready <= 1'b0;
            repeat (gap - 1) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #RUN_LIMIT;
      $display("wildcard_byte_pattern_scanner_top test failed");
      $finish;
   end

   initial begin
      logic [63:0] low;
      logic [63:0] high;
      logic [15:0] mask;
      logic [4:0]  len;
      logic [31:0] base;
      int          phase_bytes;
      int          count;
      reset    <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      psel     <= 1'b0;
      penable  <= 1'b0;
      pwrite   <= 1'b0;
      paddr    <= '0;
      pwdata   <= '0;
      run_done <= 1'b0;
      stall_on <= 1'b1;
      hold_go  <= 1'b0;
      idle_on  = 1'b1;
      cur_low  = '0;
      cur_high = '0;
      cur_mask = '0;
      cur_len  = 5'd1;
      settings_count = 1;
      mid_writes     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset signature is a single 0x00; a match, bytes after it, then a miss
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b1);

      // Overlapping start, match on the last byte, address wrapping past zero
      wait_idle();
      load_signature(64'h0000_0000_00BB_AAAA, 64'h0, 16'h0000, 5'd3, 32'hFFFF_FFFF);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'hBB, 1'b1);

      // Region shorter than the signature, even with every byte wild
      wait_idle();
      csr_write(REG_WILDCARD, 64'h7);
      send_byte(8'h5A, 1'b1);

      // A literal 0x3F in the signature is not a wildcard
      wait_idle();
      load_signature(64'h0000_0000_0041_3F41, 64'h0, 16'h0000, 5'd3, 32'h0000_0100);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h41, 1'b1);
      send_byte(8'h41, 1'b0);
      send_byte(8'h3F, 1'b0);
      send_byte(8'h41, 1'b1);

      // Bytes and wildcard bits beyond the length are ignored
      wait_idle();
      load_signature(64'hFFFF_FFFF_FFFF_5A5A, {64{1'b1}}, 16'hFFFC, 5'd2, 32'h8000_0000);
      send_byte(8'h5A, 1'b0);
      send_byte(8'h5A, 1'b1);

      // Length zero behaves as one
      wait_idle();
      csr_write(REG_LENGTH, 64'h0);
      send_byte(8'h5A, 1'b1);

      // New signature mid-region is compared against bytes already in the window
      wait_idle();
      load_signature(64'h77, 64'h0, 16'h0000, 5'd1, 32'h0000_0010);
      send_byte(8'h11, 1'b0);
      send_byte(8'h22, 1'b0);
      wait_idle();
      csr_write(REG_PATTERN_LOW, 64'h3322);
      csr_write(REG_LENGTH, 64'h2);
      cur_low = 64'h3322;
      cur_len = 5'd2;
      mid_writes++;
      send_byte(8'h33, 1'b0);
      send_byte(8'h44, 1'b1);

      // Random regions under a series of signatures
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         if (p == PHASES - 1) begin
            idle_on = 1'b0;
            stall_on <= 1'b0;
         end
         case (p)
            0: begin
               low  = {64{1'b1}};
               high = {64{1'b1}};
               mask = 16'h0000;
               len  = 5'd31;
               base = 32'hFFFF_FFFF;
            end
            1: begin
               low  = '0;
               high = '0;
               mask = 16'h0000;
               len  = 5'd0;
               base = 32'h0;
            end
            2: begin
               low  = {$urandom, $urandom};
               high = {$urandom, $urandom};
               mask = 16'hFFFF;
               len  = 5'd16;
               base = $urandom;
            end
            default: begin
               low  = {$urandom, $urandom};
               high = {$urandom, $urandom};
               if ($urandom_range(0, 2) == 0) low[15:8] = 8'h3F;
               case ($urandom_range(0, 3))
                  0: mask = 16'h0000;
                  1: mask = 16'($urandom);
                  2: mask = 16'($urandom & $urandom);
                  default: mask = 16'hFFFF;
               endcase
               if ($urandom_range(0, 3) == 0) len = 5'($urandom_range(0, 31));
               else len = 5'($urandom_range(1, 6));
               if ($urandom_range(0, 1) == 0) base = $urandom;
               else base = 32'hFFFF_FFFF - 32'($urandom_range(0, 20));
            end
         endcase
         load_signature(low, high, mask, len, base);
         if (p == 4) hold_go <= 1'b1;
         phase_bytes = 0;
         while (phase_bytes < RANDOM_BYTES / PHASES) begin
            if ($urandom_range(0, 7) == 0) count = $urandom_range(17, 48);
            else count = $urandom_range(1, 16);
            send_region(count, $urandom_range(0, 2) != 0, $urandom_range(0, 1) == 1,
                        $urandom_range(0, 11) == 0);
            phase_bytes += count;
         end
      end

      // Drain, check for leftovers, give the verdict
      wait_idle();
      run_done <= 1'b1;
      repeat (3) @(posedge clock);
      $display("Scanned %0d bytes under %0d signature settings (%0d changed mid-region);",
               byte_count, settings_count, mid_writes);
      $display("checked %0d region results, %0d of them matches.", report_count, hit_count);
      if (fail_count == 0) begin
         $display("wildcard_byte_pattern_scanner_top test passed");
      end else begin
         $display("wildcard_byte_pattern_scanner_top test failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
src/wbps_pkg.sv
src/wbps_csr.sv
src/wbps_match.sv
src/wildcard_byte_pattern_scanner_top.sv
verif/wbps_match_checker.sv
verif/tb_wildcard_byte_pattern_scanner_top.sv
